// ===== hw/rtl/akid_pkg.sv =====
// Shared types, character codes and key lookup for the key input decoder.
// No dependencies; the other files, except akid_if, refer to this package by scoped names.
package akid_pkg;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_UP      = 8'h41;  // 'A'
    localparam logic [7:0] CH_DOWN    = 8'h42;  // 'B'
    localparam logic [7:0] CH_RIGHT   = 8'h43;  // 'C'
    localparam logic [7:0] CH_LEFT    = 8'h44;  // 'D'
    localparam logic [7:0] CH_END     = 8'h46;  // 'F'
    localparam logic [7:0] CH_HOME    = 8'h48;  // 'H'

    localparam logic [2:0] KC_UP    = 3'd0;
    localparam logic [2:0] KC_DOWN  = 3'd1;
    localparam logic [2:0] KC_RIGHT = 3'd2;
    localparam logic [2:0] KC_LEFT  = 3'd3;
    localparam logic [2:0] KC_END   = 3'd4;
    localparam logic [2:0] KC_HOME  = 3'd5;

    // Decoder modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_CSI  = 2'd2;
    localparam logic [1:0] MODE_CR   = 2'd3;

    // Prefix emitted ahead of the tail result
    localparam logic [1:0] PRE_NONE   = 2'd0;
    localparam logic [1:0] PRE_ESC    = 2'd1;
    localparam logic [1:0] PRE_ESC_BR = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] npre;      // prefix code
        logic       tail;      // a tail result follows the prefix
        logic       tail_key;  // tail is a key code
        logic [7:0] tail_val;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_key;

    function automatic t_key key_lookup(input logic [7:0] b);
        t_key k;
        k.hit  = 1'b1;
        k.code = KC_UP;
        unique case (b)
            CH_UP:    k.code = KC_UP;
            CH_DOWN:  k.code = KC_DOWN;
            CH_RIGHT: k.code = KC_RIGHT;
            CH_LEFT:  k.code = KC_LEFT;
            CH_END:   k.code = KC_END;
            CH_HOME:  k.code = KC_HOME;
            default:  k.hit  = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/akid_if.sv =====
// Valid/ready stream interfaces for the key input decoder channels.
// Standalone; no package dependency.
interface akid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface akid_out_if;
    logic       valid;
    logic       ready;
    logic       is_key;
    logic [7:0] value;
    logic       last;
    modport source (output valid, output is_key, output value, output last, input ready);
    modport sink   (input valid, input is_key, input value, input last, output ready);
endinterface

// ===== hw/rtl/akid_front.sv =====
// Front end: accepts input bytes, tracks the escape/CR mode and turns each
// byte that yields results into a command for the queue. Depends on akid_pkg.
module akid_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    output logic               o_ready,
    output logic               o_push,
    output akid_pkg::t_cmd     o_cmd,
    input  logic               i_q_ready
);

    logic [1:0]     r_mode;
    logic [1:0]     n_mode;
    logic           accept;
    akid_pkg::t_key key;
    akid_pkg::t_cmd cmd;
    logic [1:0]     idle_mode;
    logic           idle_tail;
    logic [7:0]     idle_val;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign key     = akid_pkg::key_lookup(i_byte);

    // Handling of a byte as seen from idle
    always_comb begin
        if (i_byte == akid_pkg::CH_ESC) begin
            idle_mode = akid_pkg::MODE_ESC;
            idle_tail = 1'b0;
            idle_val  = i_byte;
        end else if (i_byte == akid_pkg::CH_CR) begin
            idle_mode = akid_pkg::MODE_CR;
            idle_tail = 1'b1;
            idle_val  = akid_pkg::CH_LF;
        end else begin
            idle_mode = akid_pkg::MODE_IDLE;
            idle_tail = 1'b1;
            idle_val  = i_byte;
        end
    end

    always_comb begin
        cmd.npre     = akid_pkg::PRE_NONE;
        cmd.tail     = idle_tail;
        cmd.tail_key = 1'b0;
        cmd.tail_val = idle_val;
        n_mode       = idle_mode;
        unique case (r_mode)
            akid_pkg::MODE_ESC: begin
                if (i_byte == akid_pkg::CH_BRACKET) begin
                    cmd.tail = 1'b0;
                    n_mode   = akid_pkg::MODE_CSI;
                end else begin
                    cmd.npre = akid_pkg::PRE_ESC;
                end
            end
            akid_pkg::MODE_CSI: begin
                if (key.hit) begin
                    cmd.tail     = 1'b1;
                    cmd.tail_key = 1'b1;
                    cmd.tail_val = {5'd0, key.code};
                    n_mode       = akid_pkg::MODE_IDLE;
                end else begin
                    cmd.npre = akid_pkg::PRE_ESC_BR;
                end
            end
            akid_pkg::MODE_CR: begin
                // swallow the LF of a CRLF pair
                if (i_byte == akid_pkg::CH_LF) begin
                    cmd.tail = 1'b0;
                    n_mode   = akid_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.tail || (cmd.npre != akid_pkg::PRE_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= akid_pkg::MODE_IDLE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

// ===== hw/rtl/akid_queue.sv =====
// Short command queue between front and back ends; accepts a push while
// full if the head leaves in the same cycle. Depends on akid_pkg.
module akid_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  akid_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output akid_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    akid_pkg::t_cmd                  r_mem [akid_pkg::QDEPTH];
    logic [akid_pkg::QPTR_W-1:0]     r_wptr;
    logic [akid_pkg::QPTR_W-1:0]     r_rptr;
    logic [akid_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_pop;

    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_ready = (r_cnt != akid_pkg::QCNT_W'(akid_pkg::QDEPTH)) || do_pop;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == akid_pkg::QPTR_W'(akid_pkg::QDEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == akid_pkg::QPTR_W'(akid_pkg::QDEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/akid_back.sv =====
// Back end: expands the head command into one to three results and holds
// each in the output register until transferred. Depends on akid_pkg.
module akid_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  akid_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    output logic           o_is_key,
    output logic [7:0]     o_value,
    output logic           o_last,
    input  logic           i_ready
);

    logic [1:0] r_step;
    logic       r_valid;
    logic       r_is_key;
    logic [7:0] r_value;
    logic       r_last;
    logic       load;
    logic [1:0] total;
    logic       step_last;
    logic       n_is_key;
    logic [7:0] n_value;

    assign load      = i_valid && (!r_valid || i_ready);
    assign total     = i_cmd.npre + {1'b0, i_cmd.tail};
    assign step_last = ((r_step + 2'd1) == total);
    assign o_pop     = load && step_last;

    always_comb begin
        if (r_step < i_cmd.npre) begin
            n_is_key = 1'b0;
            n_value  = (r_step == 2'd0) ? akid_pkg::CH_ESC : akid_pkg::CH_BRACKET;
        end else begin
            n_is_key = i_cmd.tail_key;
            n_value  = i_cmd.tail_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= step_last ? 2'd0 : r_step + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_key <= n_is_key;
            r_value  <= n_value;
            r_last   <= step_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_is_key = r_is_key;
    assign o_value  = r_value;
    assign o_last   = r_last;

endmodule

// ===== hw/rtl/ansi_key_input_decoder.sv =====
// Terminal key input decoder: byte stream in, characters and cursor keys out.
// Top level; depends on akid_pkg, akid_if, akid_front, akid_queue, akid_back.
//
// Input channel i_in carries one received byte per transfer. Output channel
// o_out carries results: is_key marks a key code (0 up, 1 down, 2 right,
// 3 left, 4 end, 5 home) in value, otherwise value is a character byte;
// last is set on the final result caused by an input byte.
// ESC [ A-D, F, H become one key; CR and CRLF become one LF; a broken escape
// sequence is passed on as ESC (and [) followed by the decoded byte.
// A byte is taken in every cycle while the command queue has room; bytes
// that produce no result still need a free slot to be taken.
// The first result of a byte passes through a queue slot, then the output
// register, before it is presented; the further results of the same byte
// follow in order. The output register sends one result per cycle while
// the receiver is ready.
// When the receiver stalls the output holds, the 2-entry queue fills and
// then i_in.ready drops. Synchronous reset empties the queue and output
// and returns the decoder to the plain character mode.
module ansi_key_input_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    akid_in_if.sink      i_in,
    akid_out_if.source   o_out
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    akid_pkg::t_cmd front_cmd;
    akid_pkg::t_cmd head_cmd;

    akid_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_byte    (i_in.in_byte),
        .o_ready   (i_in.ready),
        .o_push    (push),
        .o_cmd     (front_cmd),
        .i_q_ready (q_ready)
    );

    akid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    akid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_valid  (o_out.valid),
        .o_is_key (o_out.is_key),
        .o_value  (o_out.value),
        .o_last   (o_out.last),
        .i_ready  (o_out.ready)
    );

endmodule

// ===== test/akid_decode_checker.sv =====
// Scoreboard for the key input decoder: watches both streams, predicts results.
// Depends on akid_pkg and the akid_in_if / akid_out_if interfaces.
module akid_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    akid_in_if   i_in,
    akid_out_if  i_out,
    output int   o_failures,
    output int   o_pending
);

    typedef struct {
        logic       is_key;
        logic [7:0] value;
        logic       last;
    } t_decoded;

    t_decoded   expected_results[$];
    logic [1:0] decode_state;

    initial begin
        o_failures   = 0;
        o_pending    = 0;
        decode_state = akid_pkg::MODE_IDLE;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_failures++;
    endtask

    task automatic add_result(input logic key, input logic [7:0] val);
        t_decoded r;
        r.is_key = key;
        r.value  = val;
        r.last   = 1'b0;
        expected_results.push_back(r);
    endtask

    // Decode a byte as the idle decoder would.
    task automatic decode_plain(input logic [7:0] b);
        if (b == akid_pkg::CH_ESC) begin
            decode_state = akid_pkg::MODE_ESC;
        end else if (b == akid_pkg::CH_CR) begin
            decode_state = akid_pkg::MODE_CR;
            add_result(1'b0, akid_pkg::CH_LF);
        end else begin
            decode_state = akid_pkg::MODE_IDLE;
            add_result(1'b0, b);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int         queued_ahead;
        logic       key_hit;
        logic [2:0] key_code;
        t_decoded   tail;
        queued_ahead = expected_results.size();
        case (decode_state)
            akid_pkg::MODE_ESC: begin
                if (b == akid_pkg::CH_BRACKET) begin
                    decode_state = akid_pkg::MODE_CSI;
                end else begin
                    add_result(1'b0, akid_pkg::CH_ESC);
                    decode_plain(b);
                end
            end
            akid_pkg::MODE_CSI: begin
                key_hit  = 1'b1;
                key_code = akid_pkg::KC_UP;
                case (b)
                    akid_pkg::CH_UP:    key_code = akid_pkg::KC_UP;
                    akid_pkg::CH_DOWN:  key_code = akid_pkg::KC_DOWN;
                    akid_pkg::CH_RIGHT: key_code = akid_pkg::KC_RIGHT;
                    akid_pkg::CH_LEFT:  key_code = akid_pkg::KC_LEFT;
                    akid_pkg::CH_END:   key_code = akid_pkg::KC_END;
                    akid_pkg::CH_HOME:  key_code = akid_pkg::KC_HOME;
                    default:            key_hit  = 1'b0;
                endcase
                if (key_hit) begin
                    decode_state = akid_pkg::MODE_IDLE;
                    add_result(1'b1, {5'd0, key_code});
                end else begin
                    add_result(1'b0, akid_pkg::CH_ESC);
                    add_result(1'b0, akid_pkg::CH_BRACKET);
                    decode_plain(b);
                end
            end
            akid_pkg::MODE_CR: begin
                if (b == akid_pkg::CH_LF) begin
                    decode_state = akid_pkg::MODE_IDLE;
                end else begin
                    decode_plain(b);
                end
            end
            default: decode_plain(b);
        endcase
        // Mark the final result of this byte.
        if (expected_results.size() > queued_ahead) begin
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            decode_state = akid_pkg::MODE_IDLE;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_byte(i_in.in_byte);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result key=%b value=%02h last=%b",
                        i_out.is_key, i_out.value, i_out.last));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.is_key !== want.is_key)
                        report_mismatch($sformatf("is_key got %b want %b",
                            i_out.is_key, want.is_key));
                    if (i_out.value !== want.value)
                        report_mismatch($sformatf("value got %02h want %02h",
                            i_out.value, want.value));
                    if (i_out.last !== want.last)
                        report_mismatch($sformatf("last got %b want %b (value %02h)",
                            i_out.last, want.last, want.value));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/ansi_key_input_decoder_test.sv =====
// Top of the key input decoder testbench: clock, reset, byte stimulus, verdict.
// Depends on akid_pkg, akid_if, the decoder RTL and akid_decode_checker.
module ansi_key_input_decoder_test;

    localparam int RANDOM_BYTES    = 350;
    localparam int LIMIT_CYCLES    = 300000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 20;

    logic i_clk;
    logic i_rst_n;
    logic byte_taken;
    logic hold_off_req;
    logic sender_burst;
    int   failures;
    int   pending;
    int   cycle_count;

    akid_in_if  in_ch ();
    akid_out_if out_ch ();

    ansi_key_input_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    akid_decode_checker u_scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        byte_taken  = 1'b0;
        cycle_count = 0;
    end

    // Record each input transfer so the sender can see it at the falling edge.
    always @(posedge i_clk) begin
        byte_taken  <= in_ch.valid && in_ch.ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: mixes full-speed stretches, random stalls and long hold-offs.
    initial begin : receiver
        int style;
        int seg;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_off_req) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            style = $urandom_range(0, 3);
            seg   = $urandom_range(8, 40);
            repeat (seg) begin
                @(negedge i_clk);
                case (style)
                    0: out_ch.ready <= 1'b1;
                    3: begin
                        if ($urandom_range(0, 19) == 0) begin
                            out_ch.ready <= 1'b0;
                            repeat ($urandom_range(10, 30)) @(negedge i_clk);
                        end else begin
                            out_ch.ready <= 1'($urandom_range(0, 1));
                        end
                    end
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Offer one byte and hold it until the transfer; valid stays high after.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(negedge i_clk); while (!byte_taken);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_key_seq(input logic [7:0] final_byte);
        send_byte(akid_pkg::CH_ESC);
        send_byte(akid_pkg::CH_BRACKET);
        send_byte(final_byte);
    endtask

    initial begin : stimulus
        logic [7:0] key_chars [6];
        logic [7:0] noise_chars [6];
        int         sent;
        int         kind;
        bit         hold_done;
        bit         pause_done;

        key_chars   = '{akid_pkg::CH_UP, akid_pkg::CH_DOWN, akid_pkg::CH_RIGHT,
                        akid_pkg::CH_LEFT, akid_pkg::CH_END, akid_pkg::CH_HOME};
        noise_chars = '{akid_pkg::CH_ESC, akid_pkg::CH_BRACKET, akid_pkg::CH_CR,
                        akid_pkg::CH_LF, akid_pkg::CH_UP, akid_pkg::CH_HOME};
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        hold_off_req  = 1'b0;
        sender_burst  = 1'b0;
        sent          = 0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every key, CR folding, broken escapes with extreme bytes.
        foreach (key_chars[k]) send_key_seq(key_chars[k]);
        send_byte(akid_pkg::CH_CR);
        send_byte(akid_pkg::CH_CR);
        send_byte(akid_pkg::CH_LF);
        send_byte(akid_pkg::CH_ESC);
        send_byte(8'h00);
        send_key_seq(8'hFF);
        wait_drained();

        // Random: random bytes, well-formed and broken sequences, CR pairs and noise.
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) sender_burst = ~sender_burst;
            if (!hold_done && sent >= 100) begin
                hold_done    = 1'b1;
                sender_burst = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!pause_done && sent >= 220) begin
                pause_done = 1'b1;
                wait_drained();
            end
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end else if (kind < 55) begin
                send_key_seq(key_chars[$urandom_range(0, 5)]);
                sent += 3;
            end else if (kind < 65) begin
                send_byte(akid_pkg::CH_CR);
                send_byte(akid_pkg::CH_LF);
                sent += 2;
            end else if (kind < 73) begin
                send_byte(akid_pkg::CH_CR);
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end else if (kind < 83) begin
                send_byte(akid_pkg::CH_ESC);
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end else if (kind < 93) begin
                send_key_seq(8'($urandom_range(0, 255)));
                sent += 3;
            end else begin
                repeat (3) send_byte(noise_chars[$urandom_range(0, 5)]);
                sent += 3;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
